// ----- src/sds_pkg.sv -----
// ----------------------------------------------------------------------------
// sds_pkg
// Shared constants and controller/datapath interface types for the stable
// descending score sorter.
// ----------------------------------------------------------------------------
package sds_pkg;

    // Capacity of the insertion chain and stored payload width
    localparam int MAX_ENTRIES  = 64;
    localparam int PAYLOAD_BITS = 32;

    // Fixed field widths on the ports
    localparam int PAYLOAD_W = 32;
    localparam int SCORE_W   = 16;
    localparam int DATA_W    = 48;

    // Entry counter holds 0..MAX_ENTRIES
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // insert incoming word into the chain
        logic drop;      // chain full, mark the list as overflowed
        logic shift_out; // head word taken, move chain up by one
    } sds_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic full;      // chain holds MAX_ENTRIES words
        logic last_one;  // exactly one word left
    } sds_status_t;

endpackage

// ----- src/sds_ctrl.sv -----
// ----------------------------------------------------------------------------
// sds_ctrl
// Controller: collects a list on the input side, then drains the sorted
// chain on the output side, one word per accepted output handshake.
// ----------------------------------------------------------------------------
module sds_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tlast,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  sds_pkg::sds_status_t status,
    output sds_pkg::sds_cmd_t    cmd
);
    import sds_pkg::*;

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_fire;
    logic   out_fire;

    // Handshakes
    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    // Datapath commands
    always_comb
    begin
        cmd.load      = in_fire && !status.full;
        cmd.drop      = in_fire && status.full;
        cmd.shift_out = out_fire;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && s_tlast)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_fire && status.last_one)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/sds_chain.sv -----
// ----------------------------------------------------------------------------
// sds_chain
// Datapath: a chain of cells kept in descending score order. Every cell
// compares its score with the incoming key in parallel; the new word lands
// after all cells with score >= key, and the cells behind it move down one.
// Draining moves the whole chain toward cell 0, which drives the output.
// ----------------------------------------------------------------------------
module sds_chain
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  sds_pkg::sds_cmd_t               cmd,
    input  logic [sds_pkg::PAYLOAD_W-1:0]   payload,
    input  logic signed [sds_pkg::SCORE_W-1:0] score,
    output sds_pkg::sds_status_t            status,
    output logic [sds_pkg::PAYLOAD_W-1:0]   payload_out,
    output logic signed [sds_pkg::SCORE_W-1:0] score_out,
    output logic                            overflow
);
    import sds_pkg::*;

    logic [PAYLOAD_BITS-1:0]   payload_reg [MAX_ENTRIES];
    logic [PAYLOAD_BITS-1:0]   payload_next[MAX_ENTRIES];
    logic signed [SCORE_W-1:0] score_reg   [MAX_ENTRIES];
    logic signed [SCORE_W-1:0] score_next  [MAX_ENTRIES];
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      dropped_reg;
    logic                      dropped_next;
    logic [MAX_ENTRIES-1:0]    keep;
    logic [MAX_ENTRIES-1:0]    keep_prev;
    logic [PAYLOAD_BITS-1:0]   word_in;

    assign word_in = PAYLOAD_BITS'(payload);

    // Cell i holds its word when occupied and not below the incoming key
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            keep[i] = (CNT_W'(i) < count_reg) && (score_reg[i] >= score);
        end
    end

    assign keep_prev = {keep[MAX_ENTRIES-2:0], 1'b1};

    // Cell update: insert, drain or hold
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            payload_next[i] = payload_reg[i];
            score_next[i]   = score_reg[i];
        end
        if (cmd.load)
        begin
            for (int i = 1; i < MAX_ENTRIES; i++)
            begin
                if (!keep[i] && !keep_prev[i])
                begin
                    payload_next[i] = payload_reg[i-1];
                    score_next[i]   = score_reg[i-1];
                end
            end
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (!keep[i] && keep_prev[i])
                begin
                    payload_next[i] = word_in;
                    score_next[i]   = score;
                end
            end
        end
        else if (cmd.shift_out)
        begin
            for (int i = 0; i < MAX_ENTRIES - 1; i++)
            begin
                payload_next[i] = payload_reg[i+1];
                score_next[i]   = score_reg[i+1];
            end
        end
    end

    // Fill count and overflow mark
    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (cmd.load)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.shift_out)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.drop)
        begin
            dropped_next = 1'b1;
        end
        else if (cmd.shift_out && status.last_one)
        begin
            dropped_next = 1'b0;
        end
    end

    // Cell registers, no reset needed
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            payload_reg[i] <= payload_next[i];
            score_reg[i]   <= score_next[i];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    // Status and head-of-chain outputs
    always_comb
    begin
        status.full     = (count_reg == CNT_W'(MAX_ENTRIES));
        status.last_one = (count_reg == CNT_W'(1));
    end

    assign payload_out = PAYLOAD_W'(payload_reg[0]);
    assign score_out   = score_reg[0];
    assign overflow    = dropped_reg;

endmodule

// ----- src/stable_descending_score_sorter.sv -----
// ----------------------------------------------------------------------------
// stable_descending_score_sorter
// Collects a list of scored words and returns it best score first; equal
// scores keep their load order. Words beyond capacity are dropped and flagged.
// ----------------------------------------------------------------------------
//  Channel   Dir  tdata                       tlast      tuser
//  s_axis    in   payload[31:0] score[47:32]  last_in    -
//  m_axis    out  payload_out, score_out      last_out   overflow
//
//  Load: one input word per cycle; each is placed in the sorted chain in the
//  cycle it is accepted (all cells compare in parallel).
//  Drain: after the word marked last, the stored words follow at one per
//  cycle while m_tready is high, taken from the chain head; input is held
//  off until the list is drained. Reset empties the chain at once;
//  m_tready low simply holds the head word.
// ----------------------------------------------------------------------------
module stable_descending_score_sorter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // payload[31:0], score[47:32]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // payload_out[31:0], score_out[47:32]
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // overflow[0]
);
    import sds_pkg::*;

    sds_cmd_t                  cmd;
    sds_status_t               status;
    logic [PAYLOAD_W-1:0]      payload_out;
    logic signed [SCORE_W-1:0] score_out;
    logic                      overflow;

    // Controller
    sds_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Sorting chain
    sds_chain u_chain
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .payload     (s_tdata[PAYLOAD_W-1:0]),
        .score       (s_tdata[PAYLOAD_W+SCORE_W-1:PAYLOAD_W]),
        .status      (status),
        .payload_out (payload_out),
        .score_out   (score_out),
        .overflow    (overflow)
    );

    // Output word packing
    assign m_tdata    = {score_out, payload_out};
    assign m_tlast    = status.last_one;
    assign m_tuser[0] = overflow;

    // Input and output sides never open together
    assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("input and output open at once");

    // Draining never runs on an empty chain
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (status.last_one || (u_chain.count_reg != '0)))
        else $error("drain with empty chain");

    // After the final word the block is back to loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tuser[0]))
        else $error("list end did not return to load");

    // A load never happens with the chain full
    assert property (@(posedge clk) disable iff (!rst_n) !(cmd.load && status.full))
        else $error("load into full chain");

endmodule

// ----- verif/stable_descending_score_sorter_tb.sv -----
// ----------------------------------------------------------------------------
// stable_descending_score_sorter_tb
// Self-checking bench for the stable descending score sorter. Lists of
// scored words go in through s_axis. A behavioral insertion sort keeps its
// own copy of the chain and queues the sorted words that each list should
// produce. Every word on m_axis is checked field by field against the oldest
// queued word. Both sides idle at random, and the sink holds off once for a
// long stretch while a list drains.
// ----------------------------------------------------------------------------
module stable_descending_score_sorter_tb;

    import sds_pkg::*;

    // One sorted word as it should appear on m_axis
    typedef struct packed {
        logic [PAYLOAD_W-1:0]      payload;
        logic signed [SCORE_W-1:0] score;
        logic                      last;
        logic                      ovf;
    } sorted_word_t;

    // Directed row; rows flagged known carry their result typed in
    typedef struct packed {
        logic [PAYLOAD_W-1:0]      payload;
        logic signed [SCORE_W-1:0] score;
        logic                      last;
        logic                      known;
        sorted_word_t              result;
    } plan_row_t;

    localparam int PLAN_ROWS    = 17;
    localparam int WORD_TARGET  = 470;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 400;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [DATA_W-1:0]        s_tdata  = '0;   // payload[31:0], score[47:32]
    logic                     s_tlast  = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [DATA_W-1:0]        m_tdata;         // payload_out[31:0], score_out[47:32]
    logic                     m_tlast;
    logic [0:0]               m_tuser;         // overflow[0]

    // Behavioral chain state
    logic [PAYLOAD_W-1:0]      chain_payload [MAX_ENTRIES];
    logic signed [SCORE_W-1:0] chain_score   [MAX_ENTRIES];
    int                        chain_count   = 0;
    bit                        chain_dropped = 1'b0;

    sorted_word_t expected_words[$];

    int  mismatches     = 0;
    int  words_sent     = 0;
    int  lists_sent     = 0;
    int  overflow_lists = 0;
    int  words_checked  = 0;
    bit  steady         = 1'b0;
    bit  held_once      = 1'b0;

    stable_descending_score_sorter dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // 10-unit clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit, far above the slowest legal run
    initial
    begin
        #2000000;
        $display("FAIL stable_descending_score_sorter");
        $finish;
    end

    // Insert an accepted word into the chain; on the last word queue the
    // whole sorted list and empty the chain.
    task automatic insert_scored_word(input logic [PAYLOAD_W-1:0] payload,
                                      input logic signed [SCORE_W-1:0] score,
                                      input logic last);
        logic [63:0]  keep_mask;
        int           pos;
        sorted_word_t w;
        keep_mask = (64'd1 << PAYLOAD_BITS) - 64'd1;
        if (chain_count < MAX_ENTRIES)
        begin
            pos = chain_count;
            // lower scores move down, equal scores stay ahead
            while (pos > 0 && chain_score[pos-1] < score)
            begin
                chain_payload[pos] = chain_payload[pos-1];
                chain_score[pos]   = chain_score[pos-1];
                pos--;
            end
            chain_payload[pos] = payload & keep_mask[PAYLOAD_W-1:0];
            chain_score[pos]   = score;
            chain_count++;
        end
        else
        begin
            chain_dropped = 1'b1;
        end
        if (last)
        begin
            for (int k = 0; k < chain_count; k++)
            begin
                w.payload = chain_payload[k];
                w.score   = chain_score[k];
                w.last    = (k == chain_count - 1);
                w.ovf     = chain_dropped;
                expected_words.push_back(w);
            end
            if (chain_dropped)
                overflow_lists++;
            lists_sent++;
            chain_count   = 0;
            chain_dropped = 1'b0;
        end
    endtask

    // Offer one word, with a random gap ahead of it, until accepted
    task automatic send_word(input logic [PAYLOAD_W-1:0] payload,
                             input logic signed [SCORE_W-1:0] score,
                             input logic last);
        while (!steady && $urandom_range(99) < 20)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {score, payload};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
    endtask

    // Compare one accepted m_axis word with the oldest expectation
    task automatic check_sorted_word();
        sorted_word_t want;
        sorted_word_t got;
        got.payload = m_tdata[PAYLOAD_W-1:0];
        got.score   = m_tdata[DATA_W-1:PAYLOAD_W];
        got.last    = m_tlast;
        got.ovf     = m_tuser[0];
        words_checked++;
        if (expected_words.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word: payload=%h score=%0d last=%b ovf=%b",
                         got.payload, got.score, got.last, got.ovf);
        end
        else
        begin
            want = expected_words.pop_front();
            if (got.payload !== want.payload || got.score !== want.score ||
                got.last !== want.last || got.ovf !== want.ovf)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch word %0d: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                             words_checked, want.payload, want.score, want.last,
                             want.ovf, got.payload, got.score, got.last, got.ovf);
            end
        end
    endtask

    // Sink: random back-pressure plus one long hold while a list drains
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_sorted_word();
            if (!held_once && words_checked >= 40)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= steady || ($urandom_range(99) >= 20);
            end
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        plan_row_t                 plan [PLAN_ROWS];
        int                        list_idx;
        int                        list_len;
        int                        score_mode;
        logic signed [SCORE_W-1:0] score;
        logic signed [SCORE_W-1:0] corner [5];

        corner = '{16'sh8000, 16'sh8001, 16'sh7FFF, 16'sh0000, 16'shFFFF};

        plan = '{
            // single-word lists come out unchanged
            '{32'hFFFF_FFFF, 16'sh7FFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 16'sh7FFF, 1'b1, 1'b0}},
            '{32'h0000_0000, 16'sh8000, 1'b1, 1'b1, '{32'h0000_0000, 16'sh8000, 1'b1, 1'b0}},
            '{32'hA5A5_5A5A, 16'sh8001, 1'b1, 1'b1, '{32'hA5A5_5A5A, 16'sh8001, 1'b1, 1'b0}},
            // ties among mixed scores, lowest possible score included
            '{32'h0000_0011, 16'sd5,     1'b0, 1'b0, '0},
            '{32'h0000_0022, -16'sd3,    1'b0, 1'b0, '0},
            '{32'h0000_0033, 16'sd5,     1'b0, 1'b0, '0},
            '{32'h0000_0044, 16'sh7FFF,  1'b0, 1'b0, '0},
            '{32'h0000_0055, 16'sh8000,  1'b0, 1'b0, '0},
            '{32'h0000_0066, 16'sd5,     1'b1, 1'b0, '0},
            // all scores equal: load order kept
            '{32'h0000_0100, 16'sd0,     1'b0, 1'b0, '0},
            '{32'h0000_0200, 16'sd0,     1'b0, 1'b0, '0},
            '{32'h0000_0300, 16'sd0,     1'b1, 1'b0, '0},
            // ascending input gets fully reversed
            '{32'h0000_0001, -16'sd100,  1'b0, 1'b0, '0},
            '{32'h0000_0002, 16'sd0,     1'b0, 1'b0, '0},
            '{32'h0000_0003, 16'sd100,   1'b1, 1'b0, '0},
            // already in order
            '{32'h1234_5678, 16'sd1,     1'b0, 1'b0, '0},
            '{32'h8765_4321, -16'sd1,    1'b1, 1'b0, '0}
        };

        // hold reset, then release it
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (plan[i])
        begin
            send_word(plan[i].payload, plan[i].score, plan[i].last);
            insert_scored_word(plan[i].payload, plan[i].score, plan[i].last);
            if (plan[i].known)
            begin
                // single-word list: swap in the typed-in result
                void'(expected_words.pop_back());
                expected_words.push_back(plan[i].result);
            end
        end

        // random lists: mostly short, a full chain and an overflow early on
        list_idx = 0;
        while (words_sent < WORD_TARGET)
        begin
            if (list_idx == 0)
                list_len = MAX_ENTRIES;
            else if (list_idx == 1)
                list_len = MAX_ENTRIES + 3;
            else if ($urandom_range(15) == 0)
                list_len = $urandom_range(MAX_ENTRIES + 6, 40);
            else
                list_len = $urandom_range(10, 1);
            steady     = (list_idx >= 4 && list_idx < 8);
            score_mode = $urandom_range(2);
            for (int n = 0; n < list_len; n++)
            begin
                case (score_mode)
                    0:       score = $signed(16'($urandom_range(4))) - 16'sd2;
                    1:       score = 16'($urandom);
                    default: score = corner[$urandom_range(4)];
                endcase
                send_word($urandom, score, n == list_len - 1);
                insert_scored_word(s_tdata[PAYLOAD_W-1:0], score, n == list_len - 1);
            end
            list_idx++;
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // let the last list drain, then a short quiet tail
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d words in %0d lists (%0d overflowed), checked %0d sorted words.",
                 words_sent, lists_sent, overflow_lists, words_checked);
        $display("Mismatched words: %0d", mismatches);
        if (mismatches == 0)
            $display("PASS stable_descending_score_sorter");
        else
            $display("FAIL stable_descending_score_sorter");
        $finish;
    end

endmodule
